[design/assert_macros.svh]
// Assertion macros shared by the contact keeper RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define KEEP_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KEEP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/tkck_pkg.sv]
// Types, codes and the key compare for the top-k contact keeper.
// No dependencies.
package tkck_pkg;

    localparam int CAPACITY_DEFAULT = 16;
    localparam int IDX_W            = 4;
    localparam int ENTRY_COUNT_W    = 5;
    localparam int DROP_W           = 32;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [16:0]      time_fraction;
        logic [63:0]      first_owner;
        logic [31:0]      first_shape;
        logic [63:0]      second_owner;
        logic [31:0]      second_shape;
        logic [15:0]      first_slot;
        logic [15:0]      second_slot;
        logic [IDX_W-1:0] read_index;
    } contact_t;

    typedef struct packed {
        logic [ENTRY_COUNT_W-1:0] entry_count;
        logic [DROP_W-1:0]        drop_count;
        logic                     accepted;
        logic                     entry_valid;
        logic [16:0]              out_fraction;
        logic [63:0]              out_first_owner;
        logic [31:0]              out_first_shape;
        logic [63:0]              out_second_owner;
        logic [31:0]              out_second_shape;
        logic [15:0]              out_first_slot;
        logic [15:0]              out_second_slot;
    } result_t;

    // Field order is the sort key order, most significant first.
    typedef struct packed {
        logic [16:0] time_fraction;
        logic [63:0] first_owner;
        logic [31:0] first_shape;
        logic [63:0] second_owner;
        logic [31:0] second_shape;
        logic [15:0] first_slot;
        logic [15:0] second_slot;
    } entry_t;

    // Handed from each cell to the next one up.
    typedef struct packed {
        logic   displace; // new contact goes at or below this cell
        entry_t entry;
    } link_t;

    typedef struct packed {
        logic load;       // insert beat this cycle
        logic vacant;     // cell is at or past the fill count
    } cell_ctrl_t;

    // Strict lexicographic order; packed layout makes it one unsigned compare.
    function automatic logic key_before(input entry_t a, input entry_t b);
        return a < b;
    endfunction

endpackage

[design/tkck_cell.sv]
// One slot of the sorted contact chain: entry register and key compare.
// Depends on tkck_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tkck_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tkck_pkg::cell_ctrl_t  ctrl,
    input  tkck_pkg::entry_t      newc,
    input  tkck_pkg::link_t       left,
    output tkck_pkg::link_t       link
);

    tkck_pkg::entry_t entry_reg;
    tkck_pkg::entry_t entry_next;
    logic             displace;

    assign displace      = ctrl.vacant || tkck_pkg::key_before(newc, entry_reg);
    assign link.displace = displace;
    assign link.entry    = entry_reg;

    // Shift up from the neighbor, or take the new contact at the boundary.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load && displace)
        begin
            entry_next = left.displace ? left.entry : newc;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // the neighbor below only shifts in when this cell is also displaced
    `KEEP_ASSERT(a_monotone, !(left.displace && !displace), "insert boundary not monotone")
    `KEEP_ASSERT_NEXT(a_hold, !ctrl.load, entry_reg === $past(entry_reg), "cell changed w/o insert")

endmodule

[design/top_k_contact_keeper.sv]
// Top level of the top-k contact keeper: chain of tkck_cell slots, count,
// drop counter, read select and output register. Depends on tkck_pkg,
// tkck_cell and assert_macros.svh.
//
//   channel   valid           stall           beat
//   contact   contact_valid   contact_stall   contact (tkck_pkg::contact_t)
//   result    result_valid    result_stall    result  (tkck_pkg::result_t)
//
// One contact beat per cycle while contact_stall is low; each beat yields one
// result beat in the cycle after it is taken. Every cell compares the incoming
// key against its own entry in parallel, with one wide key compare per cell.
// Reset clears the fill count, drop counter and result valid; the entries
// themselves are not cleared and only positions below the count are used.
// contact_stall rises only while a finished result is held and stalled.
`include "assert_macros.svh"

module top_k_contact_keeper #(
    parameter int CAPACITY = tkck_pkg::CAPACITY_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                contact_valid,
    output logic                contact_stall,
    input  tkck_pkg::contact_t  contact,
    output logic                result_valid,
    input  logic                result_stall,
    output tkck_pkg::result_t   result
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int XW   = (CW > tkck_pkg::IDX_W) ? CW : tkck_pkg::IDX_W;
    localparam int WW   = (CW > tkck_pkg::ENTRY_COUNT_W) ? CW : tkck_pkg::ENTRY_COUNT_W;
    localparam int RD_N = (CAPACITY < (1 << tkck_pkg::IDX_W)) ? CAPACITY
                                                              : (1 << tkck_pkg::IDX_W);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);
    localparam logic [tkck_pkg::DROP_W-1:0] DROP_MAX = '1;

    logic [CW-1:0]               count_reg, count_next;
    logic [tkck_pkg::DROP_W-1:0] drop_reg, drop_next;
    logic                        result_valid_reg;
    tkck_pkg::result_t           result_reg, result_next;

    logic               take, full, do_insert, do_clear, do_read;
    tkck_pkg::entry_t   newc;
    tkck_pkg::link_t    links [CAPACITY];
    tkck_pkg::link_t    lefts [CAPACITY];
    tkck_pkg::cell_ctrl_t ctrls [CAPACITY];

    assign contact_stall = result_valid_reg && result_stall;
    assign take          = contact_valid && !contact_stall;
    assign full          = (count_reg == FULL_CNT);
    assign do_insert     = take && (contact.mode == tkck_pkg::MODE_INSERT);
    assign do_clear      = take && (contact.mode == tkck_pkg::MODE_CLEAR);
    assign do_read       = contact.mode == tkck_pkg::MODE_READ;

    assign newc.time_fraction = contact.time_fraction;
    assign newc.first_owner   = contact.first_owner;
    assign newc.first_shape   = contact.first_shape;
    assign newc.second_owner  = contact.second_owner;
    assign newc.second_shape  = contact.second_shape;
    assign newc.first_slot    = contact.first_slot;
    assign newc.second_slot   = contact.second_slot;

    // Cell 0 is the earliest contact; the bottom cell sees no neighbor.
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            assign ctrls[g].load   = do_insert;
            assign ctrls[g].vacant = (CW'(g) >= count_reg);
            if (g == 0)
            begin : g_first
                assign lefts[g] = '0;
            end
            else
            begin : g_rest
                assign lefts[g] = links[g-1];
                `KEEP_ASSERT(a_sorted, (CW'(g) >= count_reg) ||
                    !tkck_pkg::key_before(links[g].entry, links[g-1].entry),
                    "stored entries out of order")
            end
            tkck_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrls[g]),
                .newc  (newc),
                .left  (lefts[g]),
                .link  (links[g])
            );
        end
    endgenerate

    // Count, drops and the result beat.
    always_comb
    begin
        logic             accepted;
        logic             hit;
        logic [WW-1:0]    cnt_wide;
        tkck_pkg::entry_t sel;

        count_next = count_reg;
        drop_next  = drop_reg;
        accepted   = 1'b0;
        sel        = '0;

        if (do_clear)
        begin
            count_next = '0;
            drop_next  = '0;
        end
        else if (do_insert)
        begin
            if (full)
            begin
                // full store: only a key below the last entry gets in
                accepted = links[CAPACITY-1].displace;
                if (drop_reg != DROP_MAX)
                begin
                    drop_next = drop_reg + 1'b1;
                end
            end
            else
            begin
                accepted   = 1'b1;
                count_next = count_reg + 1'b1;
            end
        end

        hit = do_read && (XW'(contact.read_index) < XW'(count_reg));
        for (int i = 0; i < RD_N; i++)
        begin
            if (contact.read_index == tkck_pkg::IDX_W'(i))
            begin
                sel = links[i].entry;
            end
        end
        if (!hit)
        begin
            sel = '0;
        end

        cnt_wide = WW'(count_next);
        result_next.entry_count      = cnt_wide[tkck_pkg::ENTRY_COUNT_W-1:0];
        result_next.drop_count       = drop_next;
        result_next.accepted         = accepted;
        result_next.entry_valid      = hit;
        result_next.out_fraction     = sel.time_fraction;
        result_next.out_first_owner  = sel.first_owner;
        result_next.out_first_shape  = sel.first_shape;
        result_next.out_second_owner = sel.second_owner;
        result_next.out_second_shape = sel.second_shape;
        result_next.out_first_slot   = sel.first_slot;
        result_next.out_second_slot  = sel.second_slot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            drop_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            drop_reg  <= drop_next;
            if (take)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `KEEP_ASSERT(a_count_range, count_reg <= FULL_CNT, "fill count beyond capacity")
    `KEEP_ASSERT_NEXT(a_count_grow, do_insert && !full, count_reg == $past(count_reg) + 1'b1,
        "insert into open slot did not grow count")
    `KEEP_ASSERT_NEXT(a_drop_quiet, !(do_clear || (do_insert && full)), $stable(drop_reg),
        "drop counter moved without full insert or clear")

endmodule

[tb/contact_keeper_checker.sv]
// Scoreboard for top_k_contact_keeper. It watches both channels, predicts one
// result beat per accepted contact beat and compares the two field by field.
// Depends on tkck_pkg.
module contact_keeper_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               contact_valid,
    input  logic               contact_stall,
    input  tkck_pkg::contact_t contact,
    input  logic               result_valid,
    input  logic               result_stall,
    input  tkck_pkg::result_t  result,
    output int unsigned        fail_count,
    output int unsigned        outstanding,
    output int unsigned        checked,
    output int unsigned        stored,
    output int unsigned        entry_hits
);
    import tkck_pkg::*;

    localparam int CAP        = CAPACITY_DEFAULT;
    localparam int SHOW_LIMIT = 40;

    // Shadow of the sorted store, front entry first.
    entry_t      held [CAP];
    int unsigned fill  = 0;
    logic [31:0] drops = '0;

    result_t     due_results [$];
    int unsigned n_fail    = 0;
    int unsigned n_checked = 0;
    int unsigned n_stored  = 0;
    int unsigned n_hits    = 0;

    // Strict lexicographic key order, time first, second slot last.
    function automatic logic sorts_earlier(input entry_t a, input entry_t b);
        if (a.time_fraction != b.time_fraction) return a.time_fraction < b.time_fraction;
        if (a.first_owner != b.first_owner) return a.first_owner < b.first_owner;
        if (a.first_shape != b.first_shape) return a.first_shape < b.first_shape;
        if (a.second_owner != b.second_owner) return a.second_owner < b.second_owner;
        if (a.second_shape != b.second_shape) return a.second_shape < b.second_shape;
        if (a.first_slot != b.first_slot) return a.first_slot < b.first_slot;
        return a.second_slot < b.second_slot;
    endfunction

    // Applies one contact beat to the shadow store and returns its result.
    function automatic result_t keep_contact(input contact_t c);
        result_t r;
        entry_t  e;
        entry_t  swap;
        int      pos;
        r = '0;
        e.time_fraction = c.time_fraction;
        e.first_owner   = c.first_owner;
        e.first_shape   = c.first_shape;
        e.second_owner  = c.second_owner;
        e.second_shape  = c.second_shape;
        e.first_slot    = c.first_slot;
        e.second_slot   = c.second_slot;
        case (c.mode)
            MODE_INSERT:
            begin
                pos = -1;
                if (fill < CAP)
                begin
                    pos = fill;
                    fill++;
                end
                else
                begin
                    if (drops != '1) drops = drops + 1'b1;
                    if (sorts_earlier(e, held[CAP-1])) pos = CAP - 1;
                end
                if (pos >= 0)
                begin
                    held[pos] = e;
                    r.accepted = 1'b1;
                    // equal keys stop here, so a tie lands behind its twin
                    while (pos > 0 && sorts_earlier(held[pos], held[pos-1]))
                    begin
                        swap          = held[pos];
                        held[pos]     = held[pos-1];
                        held[pos-1]   = swap;
                        pos--;
                    end
                end
            end
            MODE_CLEAR:
            begin
                fill  = 0;
                drops = '0;
            end
            MODE_READ:
            begin
                if (c.read_index < fill)
                begin
                    r.entry_valid      = 1'b1;
                    r.out_fraction     = held[c.read_index].time_fraction;
                    r.out_first_owner  = held[c.read_index].first_owner;
                    r.out_first_shape  = held[c.read_index].first_shape;
                    r.out_second_owner = held[c.read_index].second_owner;
                    r.out_second_shape = held[c.read_index].second_shape;
                    r.out_first_slot   = held[c.read_index].first_slot;
                    r.out_second_slot  = held[c.read_index].second_slot;
                end
            end
            default:
            begin
                // spare mode: nothing moves
            end
        endcase
        r.entry_count = 5'(fill);
        r.drop_count  = drops;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            n_fail++;
            if (n_fail <= SHOW_LIMIT)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : watch_channels
        result_t want;
        result_t next;
        if (rst_n)
        begin
            // result side first: the oldest expectation belongs to an older beat
            if (result_valid && !result_stall)
            begin
                if (due_results.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= SHOW_LIMIT)
                        $display("%0t: result beat with nothing pending, expected none, actual %0h",
                                 $time, result);
                end
                else
                begin
                    want = due_results.pop_front();
                    n_checked++;
                    check_field("entry_count", want.entry_count, result.entry_count);
                    check_field("drop_count", want.drop_count, result.drop_count);
                    check_field("accepted", want.accepted, result.accepted);
                    check_field("entry_valid", want.entry_valid, result.entry_valid);
                    check_field("out_fraction", want.out_fraction, result.out_fraction);
                    check_field("out_first_owner", want.out_first_owner, result.out_first_owner);
                    check_field("out_first_shape", want.out_first_shape, result.out_first_shape);
                    check_field("out_second_owner", want.out_second_owner,
                                result.out_second_owner);
                    check_field("out_second_shape", want.out_second_shape,
                                result.out_second_shape);
                    check_field("out_first_slot", want.out_first_slot, result.out_first_slot);
                    check_field("out_second_slot", want.out_second_slot, result.out_second_slot);
                end
            end
            if (contact_valid && !contact_stall)
            begin
                next = keep_contact(contact);
                if (next.accepted) n_stored++;
                if (next.entry_valid) n_hits++;
                due_results.push_back(next);
            end
        end
        fail_count  <= n_fail;
        outstanding <= due_results.size();
        checked     <= n_checked;
        stored      <= n_stored;
        entry_hits  <= n_hits;
    end

endmodule

[tb/tb.sv]
// Top of the contact keeper testbench: clock, reset, contact stimulus, result
// stall pattern and the verdict. Depends on tkck_pkg, top_k_contact_keeper and
// contact_keeper_checker.
module tb;
    import tkck_pkg::*;

    // Mode code the block leaves unused; it must change nothing.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 550;
    localparam int SEGMENT      = 60;     // beats between changes of idle level
    localparam int HOLD_AT      = 200;    // random beat that starts the long hold-off
    localparam int LONG_HOLD    = 80;     // cycles the receiver holds off
    localparam int DRAIN_CYCLES = 8;      // quiet cycles after the last result
    // Worst case per beat is a long sender gap plus a long stall; roughly 600
    // beats then stay well under the limit.
    localparam int CYCLE_LIMIT  = 200000;

    logic     clk;
    logic     rst_n         = 1'b0;
    logic     contact_valid = 1'b0;
    logic     contact_stall;
    contact_t contact       = '0;
    logic     result_valid;
    logic     result_stall  = 1'b0;
    result_t  result;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned results_checked;
    int unsigned contacts_stored;
    int unsigned held_reads;

    // 0: no idling on either side, 1: light idling, 2: heavy idling.
    int          idle_level   = 1;
    logic        hold_off_req = 1'b0;
    int unsigned by_mode [4];
    int unsigned cycle_count  = 0;
    entry_t      recent [$];      // last few inserted keys, replayed for exact ties

    top_k_contact_keeper dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .contact_valid (contact_valid),
        .contact_stall (contact_stall),
        .contact       (contact),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result)
    );

    contact_keeper_checker scoreboard
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .contact_valid (contact_valid),
        .contact_stall (contact_stall),
        .contact       (contact),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result),
        .fail_count    (mismatches),
        .outstanding   (pending),
        .checked       (results_checked),
        .stored        (contacts_stored),
        .entry_hits    (held_reads)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Idle length shared by both sides: mostly none or short, now and then long.
    function automatic int unsigned idle_len();
        int unsigned r;
        if (idle_level == 0) return 0;
        r = $urandom_range(99);
        if (r < ((idle_level == 1) ? 70 : 35)) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Id values: a tiny pool for ties, the top value, or anything at all.
    function automatic logic [63:0] pick_id();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 4) return 64'($urandom_range(3));
        if (r == 4) return '1;
        return {$urandom, $urandom};
    endfunction

    // Random bits in every field; callers overwrite what the mode uses.
    function automatic contact_t noise_beat();
        contact_t c;
        c.mode          = 2'($urandom);
        c.time_fraction = 17'($urandom);
        c.first_owner   = {$urandom, $urandom};
        c.first_shape   = $urandom;
        c.second_owner  = {$urandom, $urandom};
        c.second_shape  = $urandom;
        c.first_slot    = 16'($urandom);
        c.second_slot   = 16'($urandom);
        c.read_index    = 4'($urandom);
        return c;
    endfunction

    function automatic contact_t insert_beat(input entry_t k);
        contact_t c;
        c               = noise_beat();
        c.mode          = MODE_INSERT;
        c.time_fraction = k.time_fraction;
        c.first_owner   = k.first_owner;
        c.first_shape   = k.first_shape;
        c.second_owner  = k.second_owner;
        c.second_shape  = k.second_shape;
        c.first_slot    = k.first_slot;
        c.second_slot   = k.second_slot;
        recent.push_back(k);
        if (recent.size() > 8) void'(recent.pop_front());
        return c;
    endfunction

    function automatic contact_t read_beat(input logic [IDX_W-1:0] idx);
        contact_t c;
        c            = noise_beat();
        c.mode       = MODE_READ;
        c.read_index = idx;
        return c;
    endfunction

    function automatic contact_t control_beat(input logic [1:0] m);
        contact_t c;
        c      = noise_beat();
        c.mode = m;
        return c;
    endfunction

    // Key ladder around a midpoint. Level 7 is the midpoint itself; level n
    // keeps the fields ahead of key field n, lowers field n by one and maxes
    // every later field, so field n alone must decide the order.
    function automatic entry_t ladder_key(input int lvl);
        entry_t mid;
        entry_t k;
        mid.time_fraction = 17'd65536;
        mid.first_owner   = 64'h8000_0000_0000_0000;
        mid.first_shape   = 32'h8000_0000;
        mid.second_owner  = 64'h8000_0000_0000_0000;
        mid.second_shape  = 32'h8000_0000;
        mid.first_slot    = 16'h8000;
        mid.second_slot   = 16'h8000;
        k.time_fraction = (lvl > 0) ? mid.time_fraction : mid.time_fraction - 1'b1;
        k.first_owner   = (lvl > 1) ? mid.first_owner
                        : (lvl == 1) ? mid.first_owner - 1'b1 : '1;
        k.first_shape   = (lvl > 2) ? mid.first_shape
                        : (lvl == 2) ? mid.first_shape - 1'b1 : '1;
        k.second_owner  = (lvl > 3) ? mid.second_owner
                        : (lvl == 3) ? mid.second_owner - 1'b1 : '1;
        k.second_shape  = (lvl > 4) ? mid.second_shape
                        : (lvl == 4) ? mid.second_shape - 1'b1 : '1;
        k.first_slot    = (lvl > 5) ? mid.first_slot
                        : (lvl == 5) ? mid.first_slot - 1'b1 : '1;
        k.second_slot   = (lvl > 6) ? mid.second_slot
                        : (lvl == 6) ? mid.second_slot - 1'b1 : '1;
        return k;
    endfunction

    // Keys lean on small pools so ties reach deep into the key; one in ten
    // replays a recent key outright.
    function automatic entry_t random_key();
        entry_t      k;
        int unsigned r;
        r = $urandom_range(99);
        if (recent.size() != 0 && r < 10) return recent[$urandom_range(recent.size() - 1)];
        case ($urandom_range(9))
            0:       k.time_fraction = '0;
            1:       k.time_fraction = 17'd65536;
            2:       k.time_fraction = '1;          // above one, raw compare
            3, 4:    k.time_fraction = 17'($urandom_range(7));
            default: k.time_fraction = 17'($urandom);
        endcase
        k.first_owner  = pick_id();
        k.first_shape  = 32'(pick_id());
        k.second_owner = pick_id();
        k.second_shape = 32'(pick_id());
        k.first_slot   = 16'(pick_id());
        k.second_slot  = 16'(pick_id());
        return k;
    endfunction

    // Mostly inserts and reads; clears are rare so the store fills and the
    // full-store replace path gets most of the traffic.
    function automatic contact_t random_beat();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return insert_beat(random_key());
        if (r < 95) return control_beat(MODE_READ);   // index left random
        if (r < 97) return control_beat(MODE_CLEAR);
        return control_beat(MODE_SPARE);
    endfunction

    // Offers one beat and returns right after the edge that accepts it.
    // Called just after a rising edge; valid only drops when a gap follows.
    task automatic send(input contact_t c);
        int unsigned gap;
        gap = idle_len();
        if (gap != 0)
        begin
            contact_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        contact_valid <= 1'b1;
        contact       <= c;
        by_mode[c.mode]++;
        @(posedge clk);
        while (contact_stall) @(posedge clk);
    endtask

    // Receiver: random stall runs, plus one long hold-off on request so the
    // output register stays full and the block has to stall contact beats.
    initial
    begin : result_drain
        int unsigned len;
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                len = idle_len();
                result_stall <= (len != 0);
                repeat ((len != 0) ? len : 1) @(posedge clk);
            end
        end
    end

    // Run limit.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        int lvl;
        int i;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part.
        send(read_beat(0));             // empty store: no entry comes back
        send(insert_beat('1));          // largest key, fraction above one
        send(insert_beat('0));          // smallest key moves to the front
        send(insert_beat('0));          // equal key settles behind its twin
        send(insert_beat(ladder_key(7)));
        for (lvl = 0; lvl < 7; lvl++)
            send(insert_beat(ladder_key(lvl)));
        repeat (5) send(insert_beat(random_key()));   // store now full
        send(insert_beat('1));          // equal to the last entry: dropped
        send(insert_beat(ladder_key(7)));   // replaces the last, ties its twin
        send(insert_beat('1));          // strictly later than the last: dropped
        send(read_beat(0));
        send(read_beat(15));
        send(control_beat(MODE_CLEAR));
        send(read_beat(0));             // cleared: nothing valid at the front
        send(control_beat(MODE_SPARE));

        // Random part, in segments with their own idle level.
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % SEGMENT == 0) idle_level = $urandom_range(2);
            if (i == HOLD_AT) hold_off_req = 1'b1;
            send(random_beat());
        end
        contact_valid <= 1'b0;

        // Drain: every expectation must be met, then a few quiet cycles to
        // catch any stray result beat.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("contact beats sent: %0d inserts, %0d reads, %0d clears, %0d in the spare mode",
                 by_mode[MODE_INSERT], by_mode[MODE_READ], by_mode[MODE_CLEAR],
                 by_mode[MODE_SPARE]);
        $display("results compared: %0d, contacts kept: %0d, reads of held entries: %0d",
                 results_checked, contacts_stored, held_reads);
        if (mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
